>>> design/drpf_pkg.sv
package drpf_pkg;

   localparam int WINDOW_SIZE  = 10;
   localparam int DIST_W       = 13;
   localparam int STATUS_W     = 4;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam logic [DIST_W-1:0]   NEAR_LIMIT    = DIST_W'(70);
   localparam logic [DIST_W-1:0]   OUT_OF_RANGE  = DIST_W'(8190);
   localparam logic [DIST_W-1:0]   THRESHOLD_RST = DIST_W'(8191);
   localparam logic [STATUS_W-1:0] STATUS_VALID  = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_OOR_A  = STATUS_W'(2);
   localparam logic [STATUS_W-1:0] STATUS_OOR_B  = STATUS_W'(4);

   localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SUM_MAX     = WINDOW_SIZE * ((1 << DIST_W) - 1);
   localparam int SUM_W       = $clog2(SUM_MAX + 1);
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WINDOW_SIZE;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = SUM_W + RECIP_W;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);
   localparam logic [SUM_W-1:0]  WIN_SUMW  = SUM_W'(WINDOW_SIZE);
   localparam logic [SUM_W-1:0]  SUM_LIMIT = SUM_W'(SUM_MAX);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_ENABLE     = 2'd0,
      CSR_RIGHT_ENABLE    = 2'd1,
      CSR_LEFT_THRESHOLD  = 2'd2,
      CSR_RIGHT_THRESHOLD = 2'd3
   } csr_index_type;

   function automatic logic [DIST_W-1:0] next_held(
      input logic [DIST_W-1:0]   held,
      input logic                ok,
      input logic [STATUS_W-1:0] status,
      input logic [DIST_W-1:0]   distance
   );
      logic [DIST_W-1:0] res;
      res = held;
      if (ok && status == STATUS_VALID) begin
         res = distance;
      end else if (status == STATUS_OOR_A || status == STATUS_OOR_B) begin
         res = OUT_OF_RANGE;
      end
      return res;
   endfunction

   function automatic logic detects(
      input logic              en,
      input logic [DIST_W-1:0] held,
      input logic [DIST_W-1:0] thr
   );
      return en && (held > NEAR_LIMIT) && (held < thr);
   endfunction

endpackage

>>> design/dual_range_presence_filter_top.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  read_ok, status, distance per side
// rsp_      out        rsp_valid / rsp_ready  presence, averages, held distances
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// one word accepted per cycle unless rsp stalls; result runs through stages a, b, c
// (window ram read, running-sum update, reciprocal multiply) and the output register (correction)
// reset clears held values, slots, running sums and window valid bits at once
// a stalled result freezes all stages; req_ready drops only while rsp stalls
module dual_range_presence_filter_top
   import drpf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_left_read_ok,
   input  logic [STATUS_W-1:0]    req_left_status,
   input  logic [DIST_W-1:0]      req_left_distance,
   input  logic                   req_right_read_ok,
   input  logic [STATUS_W-1:0]    req_right_status,
   input  logic [DIST_W-1:0]      req_right_distance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_presence,
   output logic [DIST_W-1:0]      rsp_left_average,
   output logic [DIST_W-1:0]      rsp_right_average,
   output logic [DIST_W-1:0]      rsp_left_held_out,
   output logic [DIST_W-1:0]      rsp_right_held_out,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic              left_en_ff, right_en_ff;
   logic [DIST_W-1:0] left_thr_ff, right_thr_ff;

   logic [DIST_W-1:0] left_held_ff, right_held_ff;
   logic [DIST_W-1:0] left_held_in, right_held_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WINDOW_SIZE-1:0] left_vld_ff, right_vld_ff;

   logic [DIST_W-1:0] left_mem  [WINDOW_SIZE];
   logic [DIST_W-1:0] right_mem [WINDOW_SIZE];

   logic              adv, accept;

   // stage a: ram read data and item copy
   logic              a_valid_ff;
   logic [DIST_W-1:0] a_left_rd_ff, a_right_rd_ff;
   logic              a_left_ok_ff, a_right_ok_ff;
   logic [DIST_W-1:0] a_left_held_ff, a_right_held_ff;
   logic              a_pres_ff;

   // stage b: running sums
   logic              b_valid_ff;
   logic [SUM_W-1:0]  left_sum_ff, right_sum_ff;
   logic [SUM_W-1:0]  left_sum_in, right_sum_in;
   logic [DIST_W-1:0] b_left_held_ff, b_right_held_ff;
   logic              b_pres_ff;

   // stage c: reciprocal products
   logic              c_valid_ff;
   logic [PROD_W-1:0] c_left_prod_ff, c_right_prod_ff;
   logic [SUM_W-1:0]  c_left_sum_ff, c_right_sum_ff;
   logic [DIST_W-1:0] c_left_held_ff, c_right_held_ff;
   logic              c_pres_ff;

   // output register
   logic              rsp_valid_ff;
   logic [DIST_W-1:0] left_avg_in, right_avg_in;
   logic [DIST_W-1:0] rsp_left_avg_ff, rsp_right_avg_ff;
   logic [DIST_W-1:0] rsp_left_held_ff, rsp_right_held_ff;
   logic              rsp_pres_ff;

   function automatic logic [DIST_W-1:0] fix_quot(
      input logic [PROD_W-1:0] prod,
      input logic [SUM_W-1:0]  sum
   );
      logic [DIST_W-1:0] q;
      logic [SUM_W-1:0]  r;
      q = prod[RECIP_SHIFT +: DIST_W];
      r = sum - SUM_W'(q) * WIN_SUMW;
      if (r >= WIN_SUMW) begin
         q = q + DIST_W'(1);
      end
      return q;
   endfunction

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_en_ff   <= 1'b0;
         right_en_ff  <= 1'b0;
         left_thr_ff  <= THRESHOLD_RST;
         right_thr_ff <= THRESHOLD_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_ENABLE:     left_en_ff   <= csr_write_data[0];
            CSR_RIGHT_ENABLE:    right_en_ff  <= csr_write_data[0];
            CSR_LEFT_THRESHOLD:  left_thr_ff  <= csr_write_data[DIST_W-1:0];
            CSR_RIGHT_THRESHOLD: right_thr_ff <= csr_write_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      left_held_in  = left_held_ff;
      right_held_in = right_held_ff;
      if (left_en_ff) begin
         left_held_in = next_held(left_held_ff, req_left_read_ok,
                                  req_left_status, req_left_distance);
      end
      if (right_en_ff) begin
         right_held_in = next_held(right_held_ff, req_right_read_ok,
                                   req_right_status, req_right_distance);
      end
      slot_in = (slot_ff == SLOT_LAST) ? '0 : slot_ff + SLOT_W'(1);
   end

   // window rams: read old entry, write new one at the same slot
   always_ff @(posedge clock) begin
      if (accept) begin
         a_left_rd_ff       <= left_mem[slot_ff];
         a_right_rd_ff      <= right_mem[slot_ff];
         left_mem[slot_ff]  <= left_held_in;
         right_mem[slot_ff] <= right_held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_held_ff  <= '0;
         right_held_ff <= '0;
         slot_ff       <= '0;
         left_vld_ff   <= '0;
         right_vld_ff  <= '0;
         a_valid_ff    <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         if (req_valid) begin
            left_held_ff           <= left_held_in;
            right_held_ff          <= right_held_in;
            slot_ff                <= slot_in;
            left_vld_ff[slot_ff]   <= 1'b1;
            right_vld_ff[slot_ff]  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_left_ok_ff    <= left_vld_ff[slot_ff];
         a_right_ok_ff   <= right_vld_ff[slot_ff];
         a_left_held_ff  <= left_held_in;
         a_right_held_ff <= right_held_in;
         a_pres_ff       <= detects(left_en_ff, left_held_in, left_thr_ff) ||
                            detects(right_en_ff, right_held_in, right_thr_ff);
      end
   end

   always_comb begin
      left_sum_in  = left_sum_ff + SUM_W'(a_left_held_ff)
                     - (a_left_ok_ff ? SUM_W'(a_left_rd_ff) : '0);
      right_sum_in = right_sum_ff + SUM_W'(a_right_held_ff)
                     - (a_right_ok_ff ? SUM_W'(a_right_rd_ff) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         left_sum_ff  <= '0;
         right_sum_ff <= '0;
      end else if (adv) begin
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
         if (a_valid_ff) begin
            left_sum_ff  <= left_sum_in;
            right_sum_ff <= right_sum_in;
         end
      end
   end

   always_comb begin
      left_avg_in  = fix_quot(c_left_prod_ff, c_left_sum_ff);
      right_avg_in = fix_quot(c_right_prod_ff, c_right_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_left_held_ff    <= a_left_held_ff;
         b_right_held_ff   <= a_right_held_ff;
         b_pres_ff         <= a_pres_ff;
         c_left_prod_ff    <= PROD_W'(left_sum_ff) * PROD_W'(RECIP);
         c_right_prod_ff   <= PROD_W'(right_sum_ff) * PROD_W'(RECIP);
         c_left_sum_ff     <= left_sum_ff;
         c_right_sum_ff    <= right_sum_ff;
         c_left_held_ff    <= b_left_held_ff;
         c_right_held_ff   <= b_right_held_ff;
         c_pres_ff         <= b_pres_ff;
         rsp_left_avg_ff   <= left_avg_in;
         rsp_right_avg_ff  <= right_avg_in;
         rsp_left_held_ff  <= c_left_held_ff;
         rsp_right_held_ff <= c_right_held_ff;
         rsp_pres_ff       <= c_pres_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_presence       = rsp_pres_ff;
   assign rsp_left_average   = rsp_left_avg_ff;
   assign rsp_right_average  = rsp_right_avg_ff;
   assign rsp_left_held_out  = rsp_left_held_ff;
   assign rsp_right_held_out = rsp_right_held_ff;

   a_left_sum_bound: assert property (@(posedge clock) disable iff (reset)
      left_sum_ff <= SUM_LIMIT)
      else $error("left running sum out of range");

   a_right_sum_bound: assert property (@(posedge clock) disable iff (reset)
      right_sum_ff <= SUM_LIMIT)
      else $error("right running sum out of range");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> a_valid_ff)
      else $error("accepted word missing from first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(c_left_prod_ff)
                                  && $stable(left_sum_ff))
      else $error("pipeline moved during output stall");

endmodule
